// ===== src/llns_pkg.sv =====
// ----------------------------------------------------------------------------
// llns_pkg
// Shared types and constants for the least-loaded node selector.
// ----------------------------------------------------------------------------
package llns_pkg;

  // Operation codes carried by the kind field
  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_JOIN   = 3'd2,
    OP_LEAVE  = 3'd3,
    OP_STATUS = 3'd4,
    OP_SELECT = 3'd5
  } op_t;

  // Configuration register indexes
  localparam logic REG_DEFAULT_NODE = 1'b0;
  localparam logic REG_MAX_LOAD     = 1'b1;

  localparam logic [15:0] MAX_LOAD_RESET = 16'd500;
  localparam logic [15:0] LOAD_MAX       = 16'hFFFF;

  // Control states of the top level
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN
  } state_t;

  // One table entry
  typedef struct packed {
    logic        present;
    logic        online;
    logic [15:0] load;
    logic [15:0] latency;
  } entry_t;

  // Status of the scan unit toward the sequencer
  typedef struct packed {
    logic busy;
    logic found;
  } scan_status_t;

endpackage

// ===== src/llns_table.sv =====
// ----------------------------------------------------------------------------
// llns_table
// Node table memory with one write and one registered read port. Per-entry
// valid bits make never-written entries read as an empty node.
// ----------------------------------------------------------------------------
module llns_table #(
  parameter int NODE_COUNT = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [$clog2(NODE_COUNT)-1:0] rd_addr,
  output llns_pkg::entry_t              rd_data,
  input  logic                          wr_en,
  input  logic [$clog2(NODE_COUNT)-1:0] wr_addr,
  input  llns_pkg::entry_t              wr_data
);

  llns_pkg::entry_t          mem [NODE_COUNT];
  logic [NODE_COUNT-1:0]     vld;
  llns_pkg::entry_t          mem_q;
  logic                      vld_q;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Valid bits: clear on reset, set on first write
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      vld_q <= vld[rd_addr];
    end
  end

  assign rd_data = vld_q ? mem_q : '0;

endmodule

// ===== src/llns_scan.sv =====
// ----------------------------------------------------------------------------
// llns_scan
// Score and compare pipeline for select: one entry per cycle, score
// latency + weight * load, keep the lowest score and its node number.
// ----------------------------------------------------------------------------
module llns_scan #(
  parameter int NODE_COUNT  = 16,
  parameter int LOAD_WEIGHT = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic                          in_valid,
  input  logic [$clog2(NODE_COUNT)-1:0] in_index,
  input  llns_pkg::entry_t              in_entry,
  input  logic [15:0]                   max_load,
  output llns_pkg::scan_status_t        status,
  output logic [$clog2(NODE_COUNT)-1:0] best_index
);

  localparam int AW      = $clog2(NODE_COUNT);
  localparam int SCORE_W = 16 + $clog2(LOAD_WEIGHT + 1) + 1;

  logic               sc_valid;
  logic [AW-1:0]      sc_index;
  logic [SCORE_W-1:0] sc_score;
  logic [SCORE_W-1:0] best_score;
  logic               found;
  logic               eligible;

  assign eligible = in_entry.present && in_entry.online && (in_entry.load < max_load);

  // Score stage: drop ineligible entries
  always_ff @(posedge clk) begin
    if (rst) begin
      sc_valid <= 1'b0;
    end else begin
      sc_valid <= in_valid && eligible;
    end
  end

  always_ff @(posedge clk) begin
    sc_index <= in_index;
    sc_score <= SCORE_W'(in_entry.latency) +
                SCORE_W'(in_entry.load) * SCORE_W'(LOAD_WEIGHT);
  end

  // Compare stage: strict less keeps the lower node on a tie
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      found <= 1'b0;
    end else if (sc_valid && (!found || sc_score < best_score)) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sc_valid && (!found || sc_score < best_score)) begin
      best_score <= sc_score;
      best_index <= sc_index;
    end
  end

  assign status.busy  = sc_valid;
  assign status.found = found;

endmodule

// ===== src/least_loaded_node_selector.sv =====
// ----------------------------------------------------------------------------
// least_loaded_node_selector
// Node table with add, remove, join, leave, status update and select.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// on the result ports for one cycle with done high and cannot be held off.
// Add, remove, join, leave and status update read the node's entry from the
// table memory, modify it in the access state and write it back; done is
// registered from that state. Select sweeps the table one entry per cycle
// through the memory read port and a two-stage score/compare pipeline: done
// goes high once every entry has been issued and the pipeline has drained.
// busy is high until the result is out, so the next request is taken at the
// edge that ends the done cycle. Configuration writes take effect at once
// and belong between requests.
module least_loaded_node_selector #(
  parameter int NODE_COUNT  = 16,
  parameter int LOAD_WEIGHT = 10
) (
  input  logic        clk,
  input  logic        rst,
  // request
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic [3:0]  node_id,
  input  logic        online_flag,
  input  logic [15:0] latency,
  // result
  output logic        done,
  output logic [3:0]  best_node,
  output logic        none_eligible,
  output logic        node_present,
  output logic        node_online,
  output logic [15:0] node_load,
  // configuration
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [15:0] wr_data
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam int CW = AW + 1;

  llns_pkg::state_t       state;
  llns_pkg::state_t       state_next;
  llns_pkg::entry_t       rd_data;
  llns_pkg::entry_t       cur;
  llns_pkg::entry_t       nxt;
  llns_pkg::scan_status_t scan_st;
  logic [AW-1:0]          best_index;

  logic [3:0]    default_node;
  logic [15:0]   max_load;
  logic [2:0]    kind_q;
  logic [3:0]    node_id_q;
  logic          online_q;
  logic [15:0]   latency_q;
  logic          id_ok;
  logic          accept;
  logic [CW-1:0] issue_cnt;
  logic          issue;
  logic          rd_v;
  logic [AW-1:0] rd_idx;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_mem;
  logic          scan_done;

  assign busy   = (state != llns_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign id_ok  = (32'(node_id_q) < NODE_COUNT);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      default_node <= '0;
      max_load     <= llns_pkg::MAX_LOAD_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        llns_pkg::REG_DEFAULT_NODE: default_node <= wr_data[3:0];
        llns_pkg::REG_MAX_LOAD:     max_load     <= wr_data;
      endcase
    end
  end

  // Latch request
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q    <= kind;
      node_id_q <= node_id;
      online_q  <= online_flag;
      latency_q <= latency;
    end
  end

  // Table read address: addressed node on accept, sweep index during scan
  assign issue   = (state == llns_pkg::ST_SCAN) && (issue_cnt < CW'(NODE_COUNT));
  assign rd_en   = accept || issue;
  assign rd_addr = accept ? AW'(node_id) : issue_cnt[AW-1:0];

  llns_table #(
    .NODE_COUNT (NODE_COUNT)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_mem),
    .wr_addr (AW'(node_id_q)),
    .wr_data (nxt)
  );

  // Modify the addressed entry
  assign cur = id_ok ? rd_data : '0;

  always_comb begin
    nxt    = cur;
    wr_mem = 1'b0;
    if (state == llns_pkg::ST_ACCESS && id_ok) begin
      unique case (llns_pkg::op_t'(kind_q))
        llns_pkg::OP_ADD: begin
          nxt    = '{present: 1'b1, online: 1'b1, load: '0, latency: '0};
          wr_mem = 1'b1;
        end
        llns_pkg::OP_REMOVE: begin
          nxt    = '0;
          wr_mem = 1'b1;
        end
        llns_pkg::OP_JOIN: begin
          if (cur.present && cur.load != llns_pkg::LOAD_MAX) begin
            nxt.load = cur.load + 16'd1;
            wr_mem   = 1'b1;
          end
        end
        llns_pkg::OP_LEAVE: begin
          if (cur.present && cur.load != '0) begin
            nxt.load = cur.load - 16'd1;
            wr_mem   = 1'b1;
          end
        end
        llns_pkg::OP_STATUS: begin
          if (cur.present) begin
            nxt.online  = online_q;
            nxt.latency = latency_q;
            wr_mem      = 1'b1;
          end
        end
        default: begin
          nxt    = cur;
          wr_mem = 1'b0;
        end
      endcase
    end
  end

  // Sweep counter and read-valid pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      rd_v      <= 1'b0;
    end else begin
      rd_v <= issue;
      if (state == llns_pkg::ST_ACCESS) begin
        issue_cnt <= '0;
      end else if (issue) begin
        issue_cnt <= issue_cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= issue_cnt[AW-1:0];
  end

  llns_scan #(
    .NODE_COUNT  (NODE_COUNT),
    .LOAD_WEIGHT (LOAD_WEIGHT)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .clear      (state == llns_pkg::ST_ACCESS),
    .in_valid   (rd_v),
    .in_index   (rd_idx),
    .in_entry   (rd_data),
    .max_load   (max_load),
    .status     (scan_st),
    .best_index (best_index)
  );

  assign scan_done = (state == llns_pkg::ST_SCAN) && !issue && !rd_v && !scan_st.busy;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= llns_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      llns_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = llns_pkg::ST_ACCESS;
        end
      end
      llns_pkg::ST_ACCESS: begin
        if (llns_pkg::op_t'(kind_q) == llns_pkg::OP_SELECT) begin
          state_next = llns_pkg::ST_SCAN;
        end else begin
          state_next = llns_pkg::ST_IDLE;
        end
      end
      llns_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = llns_pkg::ST_IDLE;
        end
      end
      default: state_next = llns_pkg::ST_IDLE;
    endcase
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ((state == llns_pkg::ST_ACCESS) &&
               (llns_pkg::op_t'(kind_q) != llns_pkg::OP_SELECT)) || scan_done;
    end
  end

  // Result payload: node report after the modify, select fields at scan end
  always_ff @(posedge clk) begin
    if (state == llns_pkg::ST_ACCESS) begin
      node_present  <= nxt.present;
      node_online   <= nxt.present && nxt.online;
      node_load     <= nxt.present ? nxt.load : '0;
      best_node     <= '0;
      none_eligible <= 1'b0;
    end else if (scan_done) begin
      best_node     <= scan_st.found ? 4'(best_index) : default_node;
      none_eligible <= !scan_st.found;
    end
  end

  // Checks
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in flight");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted request did not raise busy");

  a_absent_report: assert property (@(posedge clk) disable iff (rst)
    done && !node_present |-> !node_online && node_load == '0)
    else $error("absent node reported with online or load");

  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    issue_cnt <= CW'(NODE_COUNT))
    else $error("sweep counter past table size");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the least-loaded node selector against a cycle-free table model.
// Requests are driven through the start/busy handshake. Every accepted
// request is applied to a local copy of the node table, and the predicted
// outcome is queued. Each done pulse is compared field by field with the
// oldest queued outcome. Stimulus is a directed pass, a load limit check,
// then random phases under several selector settings with varying
// sender idle rates.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODE_COUNT  = 16;
  localparam int LOAD_WEIGHT = 10;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 125;
  localparam int SETTLE_CYCLES = 30;

  // Kind codes with no operation behind them
  localparam logic [2:0] KIND_UNUSED_A = 3'd6;
  localparam logic [2:0] KIND_UNUSED_B = 3'd7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  node;
    logic        online;
    logic [15:0] latency;
  } request_t;

  typedef struct packed {
    logic [3:0]  best_node;
    logic        none_eligible;
    logic        node_present;
    logic        node_online;
    logic [15:0] node_load;
  } outcome_t;

  // Node table copy, selector settings and queue of predicted outcomes
  class selector_scoreboard;
    logic        present [NODE_COUNT];
    logic        online  [NODE_COUNT];
    logic [15:0] load    [NODE_COUNT];
    logic [15:0] lat     [NODE_COUNT];
    logic [3:0]  default_node;
    logic [15:0] max_load;
    outcome_t    expected_outcomes [$];
    int          errors;

    function new();
      for (int i = 0; i < NODE_COUNT; i++) begin
        present[i] = 1'b0;
        online[i]  = 1'b0;
        load[i]    = '0;
        lat[i]     = '0;
      end
      default_node = '0;
      max_load     = llns_pkg::MAX_LOAD_RESET;
      errors       = 0;
    endfunction

    function void write_reg(logic idx, logic [15:0] data);
      if (idx == llns_pkg::REG_DEFAULT_NODE) begin
        default_node = data[3:0];
      end else begin
        max_load = data;
      end
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction

    // Apply one request to the table and work out its outcome
    function outcome_t apply_request(request_t r);
      outcome_t    o;
      logic        found;
      logic [20:0] score;
      logic [20:0] best_score;
      logic [3:0]  best_idx;
      int          n;
      n = r.node;
      o = '0;
      case (r.kind)
        llns_pkg::OP_ADD: begin
          present[n] = 1'b1;
          online[n]  = 1'b1;
          load[n]    = '0;
          lat[n]     = '0;
        end
        llns_pkg::OP_REMOVE: begin
          present[n] = 1'b0;
          online[n]  = 1'b0;
          load[n]    = '0;
          lat[n]     = '0;
        end
        llns_pkg::OP_JOIN: begin
          if (present[n] && load[n] != llns_pkg::LOAD_MAX) load[n] = load[n] + 16'd1;
        end
        llns_pkg::OP_LEAVE: begin
          if (present[n] && load[n] != 16'd0) load[n] = load[n] - 16'd1;
        end
        llns_pkg::OP_STATUS: begin
          if (present[n]) begin
            online[n] = r.online;
            lat[n]    = r.latency;
          end
        end
        llns_pkg::OP_SELECT: begin
          // Scan in node order; strict compare keeps the lower node on ties
          found      = 1'b0;
          best_score = '1;
          best_idx   = '0;
          for (int i = 0; i < NODE_COUNT; i++) begin
            if (present[i] && online[i] && load[i] < max_load) begin
              score = {5'd0, lat[i]} + 21'(LOAD_WEIGHT) * {5'd0, load[i]};
              if (!found || score < best_score) begin
                best_score = score;
                best_idx   = i[3:0];
                found      = 1'b1;
              end
            end
          end
          o.best_node     = found ? best_idx : default_node;
          o.none_eligible = !found;
        end
        default: begin
        end
      endcase
      if (present[n]) begin
        o.node_present = 1'b1;
        o.node_online  = online[n];
        o.node_load    = load[n];
      end
      return o;
    endfunction

    function void note_request(request_t r);
      outcome_t o;
      o = apply_request(r);
      expected_outcomes = {expected_outcomes, o};
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (expected_outcomes.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("[%0t] unexpected result: best=%0d none=%0d present=%0d online=%0d load=%0d",
                   $realtime, got.best_node, got.none_eligible, got.node_present,
                   got.node_online, got.node_load);
        end
        return;
      end
      want = expected_outcomes.pop_front();
      if (got.best_node !== want.best_node || got.none_eligible !== want.none_eligible ||
          got.node_present !== want.node_present || got.node_online !== want.node_online ||
          got.node_load !== want.node_load) begin
        errors++;
        if (errors <= 10) begin
          $display("[%0t] result mismatch: expected best=%0d none=%0d present=%0d online=%0d load=%0d",
                   $realtime, want.best_node, want.none_eligible, want.node_present,
                   want.node_online, want.node_load);
          $display("[%0t]                  actual   best=%0d none=%0d present=%0d online=%0d load=%0d",
                   $realtime, got.best_node, got.none_eligible, got.node_present,
                   got.node_online, got.node_load);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  kind = '0;
  logic [3:0]  node_id = '0;
  logic        online_flag = 1'b0;
  logic [15:0] latency = '0;
  logic        done;
  logic [3:0]  best_node;
  logic        none_eligible;
  logic        node_present;
  logic        node_online;
  logic [15:0] node_load;
  logic        wr_en = 1'b0;
  logic        wr_index = 1'b0;
  logic [15:0] wr_data = '0;

  int                 cycle_count = 0;
  selector_scoreboard sb = new();

  least_loaded_node_selector #(
    .NODE_COUNT  (NODE_COUNT),
    .LOAD_WEIGHT (LOAD_WEIGHT)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .node_id       (node_id),
    .online_flag   (online_flag),
    .latency       (latency),
    .done          (done),
    .best_node     (best_node),
    .none_eligible (none_eligible),
    .node_present  (node_present),
    .node_online   (node_online),
    .node_load     (node_load),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Check results first, then note a request taken at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        sb.check_result('{best_node, none_eligible, node_present, node_online, node_load});
      end
      if (start && !busy) begin
        sb.note_request('{kind, node_id, online_flag, latency});
      end
    end
  end

  // Hold the request until the block takes it; start stays high on return
  task automatic send(request_t r);
    start       <= 1'b1;
    kind        <= r.kind;
    node_id     <= r.node;
    online_flag <= r.online;
    latency     <= r.latency;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_op(logic [2:0] k, logic [3:0] n, logic onl, logic [15:0] lat);
    send('{k, n, onl, lat});
  endtask

  // Drop start for a random number of cycles
  task automatic sender_pause(int pct);
    int gap;
    gap = 0;
    while ($urandom_range(99) < pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until the last request is noted and every outcome has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write both selector registers; block must be idle
  task automatic write_settings(logic [3:0] dflt, logic [15:0] limit);
    wr_en    <= 1'b1;
    wr_index <= llns_pkg::REG_DEFAULT_NODE;
    wr_data  <= {12'd0, dflt};
    sb.write_reg(llns_pkg::REG_DEFAULT_NODE, {12'd0, dflt});
    @(posedge clk);
    wr_index <= llns_pkg::REG_MAX_LOAD;
    wr_data  <= limit;
    sb.write_reg(llns_pkg::REG_MAX_LOAD, limit);
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  function automatic request_t random_request();
    request_t r;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 10)      r.kind = llns_pkg::OP_ADD;
    else if (pick < 15) r.kind = llns_pkg::OP_REMOVE;
    else if (pick < 45) r.kind = llns_pkg::OP_JOIN;
    else if (pick < 60) r.kind = llns_pkg::OP_LEAVE;
    else if (pick < 75) r.kind = llns_pkg::OP_STATUS;
    else if (pick < 97) r.kind = llns_pkg::OP_SELECT;
    else                r.kind = $urandom_range(1) ? KIND_UNUSED_A : KIND_UNUSED_B;
    r.node   = 4'($urandom_range(15));
    r.online = ($urandom_range(9) != 0);
    // Small latencies make score ties common
    r.latency = $urandom_range(1) ? 16'($urandom_range(40)) : 16'($urandom_range(65535));
    return r;
  endfunction

  initial begin
    logic [3:0]  phase_default [7];
    logic [15:0] phase_limit   [7];
    int          phase_idle    [7];

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed pass under reset settings
    send_op(llns_pkg::OP_SELECT, 4'd0, 1'b0, 16'd0);         // empty table
    send_op(llns_pkg::OP_ADD, 4'd0, 1'b0, 16'd0);
    send_op(llns_pkg::OP_ADD, 4'd15, 1'b0, 16'd0);
    send_op(llns_pkg::OP_JOIN, 4'd15, 1'b0, 16'd0);
    send_op(llns_pkg::OP_STATUS, 4'd0, 1'b0, 16'hFFFF);      // node 0 offline
    send_op(llns_pkg::OP_SELECT, 4'd3, 1'b1, 16'hFFFF);
    send_op(llns_pkg::OP_STATUS, 4'd0, 1'b1, 16'd10);        // ties with node 15
    send_op(llns_pkg::OP_SELECT, 4'd15, 1'b0, 16'd0);
    send_op(llns_pkg::OP_LEAVE, 4'd15, 1'b0, 16'd0);
    send_op(llns_pkg::OP_LEAVE, 4'd15, 1'b0, 16'd0);         // leave at zero load
    send_op(llns_pkg::OP_JOIN, 4'd7, 1'b1, 16'd0);           // absent node
    send_op(llns_pkg::OP_LEAVE, 4'd7, 1'b1, 16'd0);
    send_op(llns_pkg::OP_STATUS, 4'd7, 1'b1, 16'h5A5A);
    send_op(llns_pkg::OP_REMOVE, 4'd7, 1'b0, 16'd0);
    send_op(llns_pkg::OP_JOIN, 4'd0, 1'b0, 16'd0);
    send_op(llns_pkg::OP_ADD, 4'd0, 1'b0, 16'd0);            // re-add present node
    send_op(llns_pkg::OP_SELECT, 4'd0, 1'b0, 16'd0);
    send_op(KIND_UNUSED_A, 4'd0, 1'b1, 16'hFFFF);
    send_op(KIND_UNUSED_B, 4'd15, 1'b0, 16'd0);
    send_op(llns_pkg::OP_REMOVE, 4'd15, 1'b0, 16'd0);
    send_op(llns_pkg::OP_REMOVE, 4'd0, 1'b0, 16'd0);
    send_op(llns_pkg::OP_SELECT, 4'd9, 1'b0, 16'd0);
    drain();

    // Drive one node up to the load limit and back below it
    write_settings(4'd15, 16'd3);
    send_op(llns_pkg::OP_ADD, 4'd9, 1'b0, 16'd0);
    send_op(llns_pkg::OP_STATUS, 4'd9, 1'b1, 16'hFFFF);
    repeat (3) send_op(llns_pkg::OP_JOIN, 4'd9, 1'b0, 16'd0);
    send_op(llns_pkg::OP_SELECT, 4'd9, 1'b0, 16'd0);
    send_op(llns_pkg::OP_LEAVE, 4'd9, 1'b0, 16'd0);
    send_op(llns_pkg::OP_SELECT, 4'd9, 1'b0, 16'd0);
    send_op(llns_pkg::OP_REMOVE, 4'd9, 1'b0, 16'd0);
    drain();

    // Random phases: settings and sender idle rate per phase
    phase_default = '{4'd15, 4'($urandom_range(15)), 4'd0, 4'd7,
                      4'($urandom_range(15)), 4'd15, 4'd3};
    phase_limit   = '{16'd4, 16'hFFFF, 16'd1, llns_pkg::MAX_LOAD_RESET,
                      16'($urandom_range(2, 12)), 16'd0, 16'd8};
    phase_idle    = '{14, 14, 14, 48, 48, 0, 0};
    for (int p = 0; p < 7; p++) begin
      write_settings(phase_default[p], phase_limit[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send(random_request());
        sender_pause(phase_idle[p]);
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/llns_pkg.sv
src/llns_table.sv
src/llns_scan.sv
src/least_loaded_node_selector.sv
dv/testbench.sv
